// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

   localparam int MAX_PATTERN_BYTES_DEFAULT     = 8;
   localparam int MAX_REPLACEMENT_BYTES_DEFAULT = 8;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int LIMIT_W     = 16;
   localparam int COUNT_W     = 17;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [LEN_W-1:0]   MATCH_LENGTH_RESET       = 4'd1;
   localparam logic [LEN_W-1:0]   REPLACEMENT_LENGTH_RESET = 4'd0;
   localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RESET       = 16'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATCH_PATTERN      = 3'd0,
      CSR_MATCH_LENGTH       = 3'd1,
      CSR_REPLACEMENT_TEXT   = 3'd2,
      CSR_REPLACEMENT_LENGTH = 3'd3,
      CSR_OUTPUT_LIMIT       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              eot;
      logic [BYTE_W-1:0] data;
   } out_entry_type;

   typedef struct packed {
      logic             accept;
      logic             shift;
      logic [LEN_W-1:0] held;
   } win_ctrl_type;

   typedef struct packed {
      logic             accept;
      logic             pop;
      logic             base;
      logic             mark_eot;
      logic [LEN_W-1:0] count;
   } out_ctrl_type;

endpackage

// ===== rtl/core/sfr_window_cell.sv =====
module sfr_window_cell import sfr_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  win_ctrl_type         ctrl,
   input  logic [BYTE_W-1:0]    in_byte,
   input  logic [BYTE_W-1:0]    neighbor_byte,
   input  logic [BYTE_W-1:0]    pattern_byte,
   output logic [BYTE_W-1:0]    cur_byte,
   output logic                 match
);

   localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   assign cur_byte = (ctrl.held == IDX) ? in_byte : byte_ff;
   assign match    = (cur_byte == pattern_byte);
   assign byte_in  = ctrl.shift ? neighbor_byte : cur_byte;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         byte_ff <= byte_in;
      end
   end

endmodule

// ===== rtl/core/sfr_out_cell.sv =====
module sfr_out_cell import sfr_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  out_ctrl_type  ctrl,
   input  out_entry_type neighbor,
   input  out_entry_type burst_here,
   input  out_entry_type burst_below,
   output out_entry_type entry
);

   localparam logic [LEN_W-1:0] IDX    = LEN_W'(INDEX);
   localparam logic [LEN_W-1:0] IDX_M1 = LEN_W'((INDEX > 0) ? INDEX - 1 : 0);
   localparam logic             IS_HEAD = (INDEX == 0);

   out_entry_type entry_ff;
   out_entry_type entry_in;
   out_entry_type chosen;
   logic          load;

   assign chosen = ctrl.base ? burst_below : burst_here;

   always_comb begin
      if (ctrl.base) begin
         load = ctrl.accept && !IS_HEAD && (ctrl.count > IDX_M1);
      end else begin
         load = ctrl.accept && (ctrl.count > IDX);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = neighbor;
      end
      if (load) begin
         entry_in = chosen;
      end
      if (ctrl.mark_eot && ctrl.base && IS_HEAD) begin
         entry_in.eot = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/stream_find_and_replace_unit.sv =====
// Streaming find-and-replace unit.
// Source bytes arrive on the req_ channel (req_in_byte, req_in_last) and the
// rewritten bytes leave on the rsp_ channel (rsp_out_byte, rsp_out_last,
// rsp_overflow); both use a valid/ready transaction. Every leftmost,
// non-overlapping occurrence of the configured pattern is replaced by the
// configured replacement text; the held window is flushed on the last byte.
// Registers are written through csr_write_enable, csr_index and
// csr_write_data; the user must do so only while the unit is idle, which
// the unit does not enforce. Each accepted byte goes through a row of
// window cells in the cycle it is accepted, and its output bytes (0 to 8)
// are loaded into a row of output cells, the first of which drives the
// rsp_ ports. A step that yields at most one byte sustains one transaction
// per cycle while the receiver keeps rsp_ready high; a step that yields n
// bytes holds req_ready low until n - 1 of them have been taken.
// When the receiver stalls, the output cells fill and req_ready falls;
// nothing is lost. Reset empties the window and the output cells, clears
// the byte count and the overflow flag, and restores the register defaults.
module stream_find_and_replace_unit import sfr_pkg::*; #(
   parameter int MAX_PATTERN_BYTES     = MAX_PATTERN_BYTES_DEFAULT,
   parameter int MAX_REPLACEMENT_BYTES = MAX_REPLACEMENT_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_in_byte,
   input  logic                   req_in_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_out_last,
   output logic                   rsp_overflow,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int P     = MAX_PATTERN_BYTES;
   localparam int R     = MAX_REPLACEMENT_BYTES;
   localparam int BURST = (P > R) ? P : R;
   localparam int DEPTH = BURST + 1;

   localparam logic [LEN_W-1:0] P_LEN = LEN_W'(P);
   localparam logic [LEN_W-1:0] R_LEN = LEN_W'(R);

   logic [P*BYTE_W-1:0] pattern_ff;
   logic [LEN_W-1:0]    mlen_ff;
   logic [R*BYTE_W-1:0] repl_ff;
   logic [LEN_W-1:0]    rlen_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   logic [LEN_W-1:0]    held_ff;
   logic [LEN_W-1:0]    held_in;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [COUNT_W-1:0]  cnt_in;
   logic                ovf_ff;
   logic                ovf_in;

   logic [LEN_W-1:0]    plen;
   logic [LEN_W-1:0]    rlen;
   logic [LEN_W-1:0]    cnt1;
   logic                full;
   logic                over;
   logic                all_match;
   logic                hit;
   logic                accept;
   logic                pop;
   logic [LEN_W-1:0]    burst_n;
   logic                empty_last;
   logic                clear_now;
   logic [COUNT_W-1:0]  cnt_inc;
   logic                ovf_now;

   logic [BYTE_W-1:0]   win_byte [P];
   logic [P-1:0]        win_match;
   logic [P-1:0]        win_used;
   logic [BYTE_W-1:0]   win_ext  [BURST];
   logic [BYTE_W-1:0]   repl_ext [BURST];

   out_entry_type       burst_ext   [DEPTH];
   out_entry_type       burst_below [DEPTH];
   out_entry_type       out_q       [DEPTH];
   out_entry_type       out_next    [DEPTH];

   win_ctrl_type        win_ctrl;
   out_ctrl_type        out_ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         mlen_ff    <= MATCH_LENGTH_RESET;
         repl_ff    <= '0;
         rlen_ff    <= REPLACEMENT_LENGTH_RESET;
         limit_ff   <= OUTPUT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MATCH_PATTERN:      pattern_ff <= csr_write_data[P*BYTE_W-1:0];
            CSR_MATCH_LENGTH:       mlen_ff    <= csr_write_data[LEN_W-1:0];
            CSR_REPLACEMENT_TEXT:   repl_ff    <= csr_write_data[R*BYTE_W-1:0];
            CSR_REPLACEMENT_LENGTH: rlen_ff    <= csr_write_data[LEN_W-1:0];
            CSR_OUTPUT_LIMIT:       limit_ff   <= csr_write_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (mlen_ff == '0) begin
         plen = LEN_W'(1);
      end else if (mlen_ff > P_LEN) begin
         plen = P_LEN;
      end else begin
         plen = mlen_ff;
      end
      rlen = (rlen_ff > R_LEN) ? R_LEN : rlen_ff;
   end

   assign accept    = req_valid && req_ready;
   assign pop       = out_q[0].valid && rsp_ready;
   assign req_ready = !out_q[1].valid;

   assign cnt1      = held_ff + LEN_W'(1);
   assign full      = (cnt1 == plen);
   assign over      = (cnt1 > plen);
   assign all_match = &(win_match | ~win_used);
   assign hit       = full && all_match;

   assign win_ctrl.accept = accept;
   assign win_ctrl.shift  = !(hit || req_in_last) && (full || over);
   assign win_ctrl.held   = held_ff;

   for (genvar i = 0; i < P; i++) begin : g_win
      logic [BYTE_W-1:0] neighbor;
      if (i == P - 1) begin : g_end
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = win_byte[i+1];
      end
      assign win_used[i] = (LEN_W'(i) < plen);
      sfr_window_cell #(
         .INDEX(i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (win_ctrl),
         .in_byte      (req_in_byte),
         .neighbor_byte(neighbor),
         .pattern_byte (pattern_ff[i*BYTE_W +: BYTE_W]),
         .cur_byte     (win_byte[i]),
         .match        (win_match[i])
      );
   end

   always_comb begin
      if (hit) begin
         burst_n = rlen;
      end else if (req_in_last) begin
         burst_n = cnt1;
      end else if (full || over) begin
         burst_n = LEN_W'(1);
      end else begin
         burst_n = '0;
      end
   end

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         if (hit || req_in_last) begin
            held_in = '0;
         end else if (full || over) begin
            held_in = held_ff;
         end else begin
            held_in = cnt1;
         end
      end
   end

   for (genvar j = 0; j < BURST; j++) begin : g_burst
      if (j < P) begin : g_w
         assign win_ext[j] = win_byte[j];
      end else begin : g_wz
         assign win_ext[j] = '0;
      end
      if (j < R) begin : g_r
         assign repl_ext[j] = repl_ff[j*BYTE_W +: BYTE_W];
      end else begin : g_rz
         assign repl_ext[j] = '0;
      end
      assign burst_ext[j].valid = 1'b1;
      assign burst_ext[j].data  = hit ? repl_ext[j] : win_ext[j];
      assign burst_ext[j].last  = req_in_last && (burst_n == LEN_W'(j + 1));
      assign burst_ext[j].eot   = req_in_last && (burst_n == LEN_W'(j + 1));
   end
   assign burst_ext[DEPTH-1] = '0;

   assign empty_last = accept && req_in_last && (burst_n == '0);
   assign clear_now  = empty_last && !(out_q[0].valid && !pop);

   assign out_ctrl.accept   = accept;
   assign out_ctrl.pop      = pop;
   assign out_ctrl.base     = out_q[0].valid && !pop;
   assign out_ctrl.mark_eot = empty_last;
   assign out_ctrl.count    = burst_n;

   for (genvar k = 0; k < DEPTH; k++) begin : g_out
      if (k == 0) begin : g_first
         assign burst_below[k] = '0;
      end else begin : g_rest
         assign burst_below[k] = burst_ext[k-1];
      end
      if (k == DEPTH - 1) begin : g_tail
         assign out_next[k] = '0;
      end else begin : g_body
         assign out_next[k] = out_q[k+1];
      end
      sfr_out_cell #(
         .INDEX(k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (out_ctrl),
         .neighbor   (out_next[k]),
         .burst_here (burst_ext[k]),
         .burst_below(burst_below[k]),
         .entry      (out_q[k])
      );
   end

   assign cnt_inc = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + COUNT_W'(1);
   assign ovf_now = ovf_ff || (cnt_inc > COUNT_W'(limit_ff));

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (clear_now) begin
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (pop) begin
         if (out_q[0].eot) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_inc;
            ovf_in = ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         held_ff <= held_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid    = out_q[0].valid;
   assign rsp_out_byte = out_q[0].data;
   assign rsp_out_last = out_q[0].last;
   assign rsp_overflow = ovf_now;

`ifndef SYNTH
   a_out_compact: assert property (@(posedge clock) disable iff (reset)
      !out_q[0].valid |-> !out_q[1].valid)
      else $error("output cells are not packed towards the head");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff < P_LEN)
      else $error("window holds more bytes than it has cells");

   a_burst_stall: assert property (@(posedge clock) disable iff (reset)
      accept && (burst_n > LEN_W'(1)) |=> !req_ready)
      else $error("input taken while a multi-byte burst is still queued");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      pop && rsp_overflow && !out_q[0].eot && !clear_now |=> ovf_ff)
      else $error("overflow flag dropped in the middle of a text");
`endif

endmodule

// ===== test/tb_stream_find_and_replace_unit.sv =====
`timescale 1ns / 1ps

module tb_stream_find_and_replace_unit import sfr_pkg::*;;

   class replace_scoreboard;
      typedef struct packed {
         logic [BYTE_W-1:0] data;
         logic              last;
         logic              ovf;
      } out_item_type;

      logic [CSR_DATA_W-1:0] pattern;
      logic [LEN_W-1:0]      pattern_len;
      logic [CSR_DATA_W-1:0] replacement;
      logic [LEN_W-1:0]      replacement_len;
      logic [LIMIT_W-1:0]    limit;

      logic [BYTE_W-1:0]  window[8];
      int unsigned        held;
      logic [COUNT_W-1:0] out_count;
      bit                 ovf_seen;
      int unsigned        step_count;

      out_item_type expected_bytes[$];
      int unsigned  errors;

      function new();
         pattern         = '0;
         pattern_len     = MATCH_LENGTH_RESET;
         replacement     = '0;
         replacement_len = REPLACEMENT_LENGTH_RESET;
         limit           = OUTPUT_LIMIT_RESET;
         foreach (window[i]) window[i] = '0;
         held       = 0;
         out_count  = '0;
         ovf_seen   = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (csr_index_type'(idx))
            CSR_MATCH_PATTERN:      pattern = value;
            CSR_MATCH_LENGTH:       pattern_len = value[LEN_W-1:0];
            CSR_REPLACEMENT_TEXT:   replacement = value;
            CSR_REPLACEMENT_LENGTH: replacement_len = value[LEN_W-1:0];
            CSR_OUTPUT_LIMIT:       limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pattern_span();
         if (pattern_len == 0) return 1;
         if (pattern_len > 8) return 8;
         return pattern_len;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      function void push_out(logic [BYTE_W-1:0] b);
         if (step_count >= 8) return;
         if (out_count != COUNT_MAX) out_count++;
         if (out_count > {1'b0, limit}) ovf_seen = 1;
         expected_bytes.push_back('{data: b, last: 1'b0, ovf: ovf_seen});
         step_count++;
      endfunction

      function void drop_oldest();
         for (int unsigned i = 0; i + 1 < held; i++) window[i] = window[i + 1];
         held--;
      endfunction

      function void note_input(logic [BYTE_W-1:0] b, logic last);
         int unsigned plen;
         int unsigned rlen;
         bit          hit;
         plen = pattern_span();
         rlen = (replacement_len > 8) ? 8 : replacement_len;
         step_count = 0;
         if (held < 8) begin
            window[held] = b;
            held++;
         end
         if (held > plen) begin
            push_out(window[0]);
            drop_oldest();
         end else if (held == plen) begin
            hit = 1;
            for (int unsigned i = 0; i < plen; i++) begin
               if (window[i] != pattern[8*i +: 8]) hit = 0;
            end
            if (hit) begin
               for (int unsigned i = 0; i < rlen; i++) push_out(replacement[8*i +: 8]);
               held = 0;
            end else begin
               push_out(window[0]);
               drop_oldest();
            end
         end
         if (last) begin
            for (int unsigned i = 0; i < held; i++) push_out(window[i]);
            if (step_count > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            held      = 0;
            out_count = '0;
            ovf_seen  = 0;
         end
      endfunction

      function void check_output(logic [BYTE_W-1:0] b, logic last, logic ovf);
         out_item_type e;
         if (expected_bytes.size() == 0) begin
            $error("unexpected output transaction: out_byte 0x%02h", b);
            errors++;
            return;
         end
         e = expected_bytes.pop_front();
         if (b !== e.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", e.data, b);
            errors++;
         end
         if (last !== e.last) begin
            $error("out_last: expected %0b, actual %0b", e.last, last);
            errors++;
         end
         if (ovf !== e.ovf) begin
            $error("overflow: expected %0b, actual %0b", e.ovf, ovf);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_in_byte = '0;
   logic                   req_in_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_out_last;
   logic                   rsp_overflow;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   replace_scoreboard     sb = new();
   int unsigned           send_idle_pct = 0;
   int unsigned           stall_pct = 0;
   int unsigned           hold_off_cycles = 0;
   logic [BYTE_W-1:0]     symbols[3];
   logic [CSR_DATA_W-1:0] phase_pattern;

   stream_find_and_replace_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_overflow     (rsp_overflow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         sb.check_output(rsp_out_byte, rsp_out_last, rsp_overflow);
      end
   end

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Entered and left at a falling edge; valid stays high on return.
   task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_input(b, last);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] pattern,
                            input logic [LEN_W-1:0] mlen,
                            input logic [CSR_DATA_W-1:0] repl,
                            input logic [LEN_W-1:0] rlen,
                            input logic [LIMIT_W-1:0] lim);
      write_csr(CSR_MATCH_PATTERN, pattern);
      write_csr(CSR_MATCH_LENGTH, CSR_DATA_W'(mlen));
      write_csr(CSR_REPLACEMENT_TEXT, repl);
      write_csr(CSR_REPLACEMENT_LENGTH, CSR_DATA_W'(rlen));
      write_csr(CSR_OUTPUT_LIMIT, CSR_DATA_W'(lim));
      csr_write_enable <= 1'b0;
   endtask

   // Waits for every expected byte, then lets the window logic settle.
   task automatic settle();
      int unsigned guard;
      guard = 0;
      while (sb.pending() != 0 && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic random_settings();
      logic [LEN_W-1:0]   mlen;
      logic [LEN_W-1:0]   rlen;
      logic [LIMIT_W-1:0] lim;
      int unsigned        pick;
      for (int i = 0; i < 3; i++) symbols[i] = 8'($urandom);
      for (int i = 0; i < 8; i++) phase_pattern[8*i +: 8] = symbols[$urandom_range(0, 2)];
      pick = $urandom_range(0, 9);
      mlen = (pick < 2) ? 4'($urandom_range(0, 15)) :
             (pick < 4) ? 4'd8 : 4'($urandom_range(1, 4));
      pick = $urandom_range(0, 9);
      rlen = (pick < 2) ? 4'($urandom_range(0, 15)) :
             (pick < 4) ? 4'd8 : 4'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      lim  = (pick < 4) ? 16'($urandom_range(0, 12)) :
             (pick < 6) ? 16'hFFFF : 16'($urandom_range(13, 60));
      configure(phase_pattern, mlen, {$urandom, $urandom}, rlen, lim);
   endtask

   task automatic random_text(input int unsigned n_items, input logic end_text);
      logic [BYTE_W-1:0] chunk[$];
      logic [BYTE_W-1:0] next_byte;
      int unsigned       plen;
      plen = sb.pattern_span();
      for (int unsigned k = 0; k < n_items; k++) begin
         if (chunk.size() == 0) begin
            if ($urandom_range(0, 9) < 4) begin
               for (int unsigned i = 0; i < plen; i++) chunk.push_back(phase_pattern[8*i +: 8]);
            end else if ($urandom_range(0, 6) == 0) begin
               chunk.push_back(8'($urandom));
            end else begin
               chunk.push_back(symbols[$urandom_range(0, 2)]);
            end
         end
         next_byte = chunk.pop_front();
         offer_byte(next_byte, (k + 1 == n_items) ? end_text : ($urandom_range(0, 11) == 0));
      end
      req_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned random_items;
      int unsigned phase;
      int unsigned n;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Unused register indexes must be ignored.
      for (int i = int'(CSR_OUTPUT_LIMIT) + 1; i < (1 << CSR_INDEX_W); i++) begin
         write_csr(CSR_INDEX_W'(i), {$urandom, $urandom});
      end
      csr_write_enable <= 1'b0;
      @(negedge clock);

      // Default settings: zero bytes are deleted and the text ends without output.
      offer_byte(8'h00, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h5A, 1'b0);
      offer_byte(8'h00, 1'b1);
      req_valid <= 1'b0;
      settle();

      // Leftmost, non-overlapping matches with an expanding replacement.
      configure(64'h6261, 4'd2, 64'h5A5958, 4'd3, 16'hFFFF);
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h62, 1'b0);
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h62, 1'b0);
      offer_byte(8'h62, 1'b0);
      offer_byte(8'h61, 1'b1);
      req_valid <= 1'b0;
      settle();

      // Oversized lengths are clamped; a zero limit flags every byte.
      configure('1, 4'hF, 64'h8877665544332211, 4'hF, 16'd0);
      for (int i = 0; i < 9; i++) offer_byte(8'hFF, 1'b0);
      offer_byte(8'h00, 1'b1);
      req_valid <= 1'b0;
      settle();

      // The pattern is shortened while the window still holds part of a text.
      configure(64'h64636261, 4'd4, 64'h5A, 4'd1, 16'd3);
      offer_byte(8'h61, 1'b0);
      offer_byte(8'h62, 1'b0);
      offer_byte(8'h63, 1'b0);
      req_valid <= 1'b0;
      settle();
      configure(64'h71, 4'd0, 64'h5A, 4'd1, 16'd3);
      offer_byte(8'h78, 1'b0);
      offer_byte(8'h79, 1'b1);
      req_valid <= 1'b0;
      settle();

      random_items = 0;
      phase = 0;
      while (random_items < 250) begin
         random_settings();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         if (phase == 0) hold_off_cycles = 300;
         n = $urandom_range(30, 50);
         random_text(n, $urandom_range(0, 9) < 7);
         random_items += n;
         settle();
         phase++;
      end

      if (sb.pending() != 0) begin
         $error("%0d expected output transactions never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_window_cell.sv
rtl/core/sfr_out_cell.sv
rtl/core/stream_find_and_replace_unit.sv
test/tb_stream_find_and_replace_unit.sv
